>>> rtl/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, held off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

>>> rtl/xss_pkg.sv
`default_nettype none

package xss_pkg;

  localparam int unsigned XSS_WORD_W   = 32;
  localparam int unsigned XSS_ACTION_W = 2;

  localparam logic [XSS_WORD_W-1:0] MUL_STAR  = 32'h9e3779bb;
  localparam logic [XSS_WORD_W-1:0] MUL_FIVE  = 32'd5;
  localparam logic [XSS_WORD_W-1:0] SEED_ADD0 = 32'd193;
  localparam logic [XSS_WORD_W-1:0] SEED_ADD1 = 32'd7771;
  localparam logic [XSS_WORD_W-1:0] MIX_A     = 32'd522133279;
  localparam logic [XSS_WORD_W-1:0] MIX_B     = 32'd93444155;
  localparam logic [XSS_WORD_W-1:0] MIX_C     = 32'd720880126;
  localparam logic [XSS_WORD_W-1:0] MIX_D     = 32'd1665791465;

  localparam int unsigned ROT_STAR = 5;
  localparam int unsigned ROT_A    = 26;
  localparam int unsigned SHIFT_B  = 9;
  localparam int unsigned ROT_C    = 13;

  typedef enum logic [XSS_ACTION_W-1:0] {
    ACT_SEED  = 2'd0,
    ACT_RAW   = 2'd1,
    ACT_RANGE = 2'd2
  } xss_action_e;

  typedef enum logic [3:0] {
    ST_BOOT,
    ST_IDLE,
    ST_SD_MA,
    ST_SD_MB,
    ST_SD_MC,
    ST_SD_MD,
    ST_SD_FIN,
    ST_ADV_M1,
    ST_ADV_M2,
    ST_ADV_DONE,
    ST_DIV,
    ST_RESULT
  } xss_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } xss_div_stat_t;

  function automatic logic [XSS_WORD_W-1:0] rotl(input logic [XSS_WORD_W-1:0] v,
                                                 input int unsigned amt);
    rotl = (v << amt) | (v >> (XSS_WORD_W - amt));
  endfunction

endpackage

`default_nettype wire

>>> rtl/xss_if.sv
`default_nettype none

interface xss_in_if import xss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [XSS_ACTION_W-1:0] action;
  logic [XSS_WORD_W-1:0]   seed_first;
  logic [XSS_WORD_W-1:0]   seed_second;
  logic [XSS_WORD_W-1:0]   range_low;
  logic [XSS_WORD_W-1:0]   range_high;

  modport source (output valid, action, seed_first, seed_second, range_low, range_high,
                  input ready);
  modport sink   (input valid, action, seed_first, seed_second, range_low, range_high,
                  output ready);
endinterface

interface xss_out_if import xss_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [XSS_WORD_W-1:0] value;

  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

`default_nettype wire

>>> rtl/xoroshiro64_starstar_rng_unit.sv
// Raw request: ADV_M1, ADV_M2, ADV_DONE, then RESULT loads the output register once it is free.
// Seed request: SD_MA to SD_FIN through the shared multiplier, then an advance, no result beat.
// Range request: advance, then the one-bit-per-cycle remainder unit (32 steps) for nonzero span.
// A new request is taken once the previous result is in the output register.
// After reset the sequencer seeds the state with both seed words zero
// before the first request is accepted.
`default_nettype none
`include "assert_macros.svh"

module xoroshiro64_starstar_rng_unit import xss_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  xss_in_if.sink    in_i,
  xss_out_if.source out_o
);

  xss_state_e  state_q, state_d;
  xss_action_e act_q, act_d;
  logic        out_vld_q, out_vld_d;

  logic [XSS_WORD_W-1:0] w0_q, w0_d;
  logic [XSS_WORD_W-1:0] w1_q, w1_d;
  logic [XSS_WORD_W-1:0] p_q, p_d;
  logic [XSS_WORD_W-1:0] q_q, q_d;
  logic [XSS_WORD_W-1:0] x_q, x_d;
  logic [XSS_WORD_W-1:0] lo_q, lo_d;
  logic [XSS_WORD_W-1:0] span_q, span_d;
  logic [XSS_WORD_W-1:0] res_q, res_d;
  logic [XSS_WORD_W-1:0] mul_q, mul_d;
  logic [XSS_WORD_W-1:0] out_value_q, out_value_d;
  logic [XSS_WORD_W-1:0] op_a, op_b;
  logic [XSS_WORD_W-1:0] s1x;

  logic                  div_start;
  xss_div_stat_t         div_stat;
  logic [XSS_WORD_W-1:0] div_rem;

  xss_divu #(
    .Width (XSS_WORD_W)
  ) u_divu (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (mul_q),
    .divisor_i   (span_q),
    .stat_o      (div_stat),
    .remainder_o (div_rem)
  );

  always_comb begin
    case (state_q)
      ST_SD_MA:  begin op_a = p_q;                    op_b = MIX_A;    end
      ST_SD_MB:  begin op_a = q_q;                    op_b = MIX_B;    end
      ST_SD_MC:  begin op_a = p_q;                    op_b = MIX_C;    end
      ST_SD_MD:  begin op_a = q_q;                    op_b = MIX_D;    end
      ST_ADV_M1: begin op_a = w0_q;                   op_b = MUL_STAR; end
      ST_ADV_M2: begin op_a = rotl(mul_q, ROT_STAR);  op_b = MUL_FIVE; end
      default:   begin op_a = '0;                     op_b = '0;       end
    endcase
  end

  assign mul_d = op_a * op_b;
  assign s1x   = w1_q ^ w0_q;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    out_vld_d   = out_vld_q;
    w0_d        = w0_q;
    w1_d        = w1_q;
    p_d         = p_q;
    q_d         = q_q;
    x_d         = x_q;
    lo_d        = lo_q;
    span_d      = span_q;
    res_d       = res_q;
    out_value_d = out_value_q;
    div_start   = 1'b0;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_BOOT: begin
        p_d     = SEED_ADD0;
        q_d     = SEED_ADD1;
        act_d   = ACT_SEED;
        state_d = ST_SD_MA;
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          case (xss_action_e'(in_i.action))
            ACT_SEED: begin
              act_d   = ACT_SEED;
              p_d     = in_i.seed_first + SEED_ADD0;
              q_d     = in_i.seed_second + SEED_ADD1;
              state_d = ST_SD_MA;
            end
            ACT_RAW: begin
              act_d   = ACT_RAW;
              state_d = ST_ADV_M1;
            end
            ACT_RANGE: begin
              act_d   = ACT_RANGE;
              lo_d    = in_i.range_low;
              span_d  = in_i.range_high - in_i.range_low + 1'b1;
              state_d = ST_ADV_M1;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SD_MA: state_d = ST_SD_MB;
      ST_SD_MB: begin
        x_d     = mul_q;
        state_d = ST_SD_MC;
      end
      ST_SD_MC: begin
        w0_d    = x_q ^ mul_q;
        state_d = ST_SD_MD;
      end
      ST_SD_MD: begin
        x_d     = mul_q;
        state_d = ST_SD_FIN;
      end
      ST_SD_FIN: begin
        w1_d    = x_q ^ mul_q;
        state_d = ST_ADV_M1;
      end
      ST_ADV_M1: state_d = ST_ADV_M2;
      ST_ADV_M2: begin
        w0_d    = rotl(w0_q, ROT_A) ^ s1x ^ (s1x << SHIFT_B);
        w1_d    = rotl(s1x, ROT_C);
        state_d = ST_ADV_DONE;
      end
      ST_ADV_DONE: begin
        case (act_q)
          ACT_SEED: state_d = ST_IDLE;
          ACT_RANGE: begin
            if (span_q == '0) begin
              res_d   = mul_q;
              state_d = ST_RESULT;
            end else begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end
          default: begin
            res_d   = mul_q;
            state_d = ST_RESULT;
          end
        endcase
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_d   = lo_q + div_rem;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_vld_q || out_o.ready) begin
          out_value_d = res_q;
          out_vld_d   = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_BOOT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_BOOT;
      act_q     <= ACT_SEED;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      act_q     <= act_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w0_q        <= w0_d;
    w1_q        <= w1_d;
    p_q         <= p_d;
    q_q         <= q_d;
    x_q         <= x_d;
    lo_q        <= lo_d;
    span_q      <= span_d;
    res_q       <= res_d;
    mul_q       <= mul_d;
    out_value_q <= out_value_d;
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.value = out_value_q;

  `ASSERT_CLK(a_div_span_nonzero, clk_i, rst_ni, div_start |-> (span_q != '0))
  `ASSERT_CLK(a_div_idle_at_start, clk_i, rst_ni, div_start |-> !div_stat.busy)
  `ASSERT_CLK(a_div_done_in_wait, clk_i, rst_ni, div_stat.done |-> (state_q == ST_DIV))
  `ASSERT_CLK(a_result_holds, clk_i, rst_ni,
              (state_q == ST_RESULT && out_vld_q && !out_o.ready) |=> (state_q == ST_RESULT))

endmodule

`default_nettype wire

>>> rtl/xss_divu.sv
`default_nettype none

module xss_divu import xss_pkg::*; #(
  parameter int unsigned Width = XSS_WORD_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  output xss_div_stat_t         stat_o,
  output logic      [Width-1:0] remainder_o
);

  localparam int unsigned CntW = (Width > 1) ? $clog2(Width) : 1;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [Width-1:0] rem_q, quo_q, div_q;
  logic [Width:0]   shifted;
  logic [Width:0]   diff;

  // One restoring step a cycle while busy; for a nonzero divisor the remainder stays below the divisor.
  assign shifted = {rem_q, quo_q[Width-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(Width - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= diff[Width] ? shifted[Width-1:0] : diff[Width-1:0];
      quo_q <= quo_q << 1;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire
